// File: hw/rtl/qri_pkg.sv
// Package for the quaternion rate integrator: field widths, register indexes,
// multiplier operand widths and the kinematic term table.
// No dependencies.
`default_nettype none

package qri_pkg;

    localparam int COMPONENT_WIDTH_DEF = 32;

    localparam int FIELD_W  = 32;   // width of every rate, load and result field
    localparam int DT_W     = 24;   // step_time register width
    localparam int CFG_IDX_W = 2;   // config index, wide enough to see a stray write

    // shared multiplier: 32 x 25 signed, registered product
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RENORM    = 2'd1;

    localparam logic [DT_W-1:0] STEP_TIME_RST = 24'd16777;
    localparam logic            RENORM_RST    = 1'b1;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] QC_W = 2'd0;
    localparam logic [1:0] QC_X = 2'd1;
    localparam logic [1:0] QC_Y = 2'd2;
    localparam logic [1:0] QC_Z = 2'd3;

    typedef struct packed {
        logic [1:0] hsel;   // which half-angle term
        logic [1:0] qsel;   // which old component
        logic       neg;    // subtract the product
    } term_t;

    // Omega(w) * q, one product term of one output component
    function automatic term_t step_term(input logic [1:0] comp, input logic [1:0] idx);
        term_t t;
        t = '{hsel: AX_X, qsel: QC_W, neg: 1'b0};
        unique case ({comp, idx})
            {QC_W, 2'd0}: t = '{hsel: AX_X, qsel: QC_X, neg: 1'b1};
            {QC_W, 2'd1}: t = '{hsel: AX_Y, qsel: QC_Y, neg: 1'b1};
            {QC_W, 2'd2}: t = '{hsel: AX_Z, qsel: QC_Z, neg: 1'b1};
            {QC_X, 2'd0}: t = '{hsel: AX_X, qsel: QC_W, neg: 1'b0};
            {QC_X, 2'd1}: t = '{hsel: AX_Z, qsel: QC_Y, neg: 1'b0};
            {QC_X, 2'd2}: t = '{hsel: AX_Y, qsel: QC_Z, neg: 1'b1};
            {QC_Y, 2'd0}: t = '{hsel: AX_Y, qsel: QC_W, neg: 1'b0};
            {QC_Y, 2'd1}: t = '{hsel: AX_Z, qsel: QC_X, neg: 1'b1};
            {QC_Y, 2'd2}: t = '{hsel: AX_X, qsel: QC_Z, neg: 1'b0};
            {QC_Z, 2'd0}: t = '{hsel: AX_Z, qsel: QC_W, neg: 1'b0};
            {QC_Z, 2'd1}: t = '{hsel: AX_Y, qsel: QC_X, neg: 1'b0};
            {QC_Z, 2'd2}: t = '{hsel: AX_X, qsel: QC_Y, neg: 1'b1};
            default:      t = '{hsel: AX_X, qsel: QC_W, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qri_if.sv
// Channel interfaces of the quaternion rate integrator: request, result and
// configuration write. Depends on qri_pkg.
`default_nettype none

interface qri_req_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic signed [qri_pkg::FIELD_W-1:0] rate_x;
    logic signed [qri_pkg::FIELD_W-1:0] rate_y;
    logic signed [qri_pkg::FIELD_W-1:0] rate_z;
    logic signed [qri_pkg::FIELD_W-1:0] load_w;
    logic signed [qri_pkg::FIELD_W-1:0] load_x;
    logic signed [qri_pkg::FIELD_W-1:0] load_y;
    logic signed [qri_pkg::FIELD_W-1:0] load_z;

    modport source (output valid, op, rate_x, rate_y, rate_z, load_w, load_x, load_y, load_z,
                    input ready);
    modport sink (input valid, op, rate_x, rate_y, rate_z, load_w, load_x, load_y, load_z,
                  output ready);
endinterface

interface qri_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [qri_pkg::FIELD_W-1:0] att_w;
    logic signed [qri_pkg::FIELD_W-1:0] att_x;
    logic signed [qri_pkg::FIELD_W-1:0] att_y;
    logic signed [qri_pkg::FIELD_W-1:0] att_z;

    modport source (output valid, att_w, att_x, att_y, att_z, input ready);
    modport sink (input valid, att_w, att_x, att_y, att_z, output ready);
endinterface

interface qri_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [qri_pkg::CFG_IDX_W-1:0]      index;
    logic [qri_pkg::DT_W-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qri_mul.sv
// Shared signed multiplier with a registered product.
// Depends on qri_pkg.
`default_nettype none

module qri_mul (
    input  logic                                clk,
    input  logic signed [qri_pkg::MUL_A_W-1:0]  a,
    input  logic signed [qri_pkg::MUL_B_W-1:0]  b,
    output logic signed [qri_pkg::MUL_P_W-1:0]  p
);
    import qri_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: hw/rtl/qri_sqrt.sv
// Bit-serial integer square root (floor), one result bit per cycle.
// Depends on qri_pkg.
`default_nettype none

module qri_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [62:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import qri_pkg::*;

    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= {1'b0, radicand};
                root_reg <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
                cnt_reg  <= '0;
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg[31:0];

endmodule

`default_nettype wire

// File: hw/rtl/qri_div.sv
// Restoring divider, 64 / 32 bits, one quotient bit per cycle; flags a
// quotient that does not fit 32 bits. Depends on qri_pkg.
`default_nettype none

module qri_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quot,
    output logic        ovf
);
    import qri_pkg::*;

    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic        ovf_reg;
    logic [32:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[31]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvs_reg <= divisor;
                cnt_reg <= '0;
                if (dividend >= {divisor, 32'd0})
                begin
                    ovf_reg  <= 1'b1;
                    done_reg <= 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b0;
                    rem_reg <= dividend[63:32];
                    quo_reg <= dividend[31:0];
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                rem_reg <= fits ? 32'(shifted - {1'b0, dvs_reg}) : shifted[31:0];
                quo_reg <= {quo_reg[30:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_rate_integrator.sv
// Quaternion rate integrator, top level. Uses qri_pkg, qri_if, qri_mul,
// qri_sqrt and qri_div.
// Sequence: a load goes straight to the result stage; an integrate forms three
// half-angle products, then 24 half-products for the step; with renormalisation it
// adds eight half-products for the squares, a square root and four divides, and
// skips the divides when the norm is zero.
// One request at a time: ready returns when the result is registered, and a result
// still held stalls the next.
// Reset: attitude to identity, step_time 16777, renormalize 1, no result held.
`default_nettype none

module quaternion_rate_integrator #(
    parameter int COMPONENT_WIDTH = qri_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    qri_req_if.sink    req,
    qri_res_if.source  res,
    qri_cfg_if.sink    cfg
);
    import qri_pkg::*;

    localparam int CW  = COMPONENT_WIDTH;
    localparam int F   = CW - 2;                    // fraction bits of a component
    localparam int SHR = (F >= 30) ? F - 30 : 0;    // component -> Q1.30 right shift
    localparam int SHL = (F < 30) ? 30 - F : 0;     // component -> Q1.30 left shift
    localparam int BW  = (CW > MUL_B_W) ? CW : MUL_B_W;
    localparam int AW  = BW + 35;                   // sum of three 32 x BW products
    localparam int XW  = BW + 70;                   // roomy width for shifts and clamps

    localparam logic signed [XW-1:0] CMAX = XW'((longint'(1) <<< (CW - 1)) - 1);
    localparam logic signed [XW-1:0] CMIN = -CMAX - XW'(1);
    localparam logic signed [XW-1:0] QMAX = XW'(longint'(2147483647));
    localparam logic signed [XW-1:0] QMIN = -QMAX - XW'(1);
    localparam logic signed [CW-1:0] ONE  = CW'(longint'(1) <<< F);
    localparam logic signed [AW-1:0] HALF_LSB = AW'(longint'(1) <<< 29);

    typedef enum logic [3:0] {
        S_IDLE, S_HMUL, S_HACC, S_QMUL, S_QACC, S_SMUL, S_SACC,
        S_SQST, S_SQRT, S_DVST, S_DIV, S_DONE
    } state_t;

    function automatic logic signed [31:0] sat_q32(input logic signed [XW-1:0] v);
        logic signed [31:0] r;
        if (v > QMAX)
            r = 32'sh7fff_ffff;
        else if (v < QMIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sat_comp(input logic signed [XW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > CMAX)
            r = CMAX[CW-1:0];
        else if (v < CMIN)
            r = CMIN[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    function automatic logic signed [31:0] to_q30(input logic signed [CW-1:0] v);
        return sat_q32((XW'(v) <<< SHL) >>> SHR);
    endfunction

    function automatic logic signed [CW-1:0] from_q30(input logic signed [31:0] v);
        return sat_comp((XW'(v) <<< SHR) >>> SHL);
    endfunction

    state_t                state_reg;
    logic [DT_W-1:0]       dt_reg;
    logic                  renorm_reg;
    logic signed [CW-1:0]  att_reg [4];
    logic signed [CW-1:0]  qn_reg [3];
    logic signed [31:0]    rate_reg [3];
    logic signed [31:0]    h_reg [3];
    logic [1:0]            k_reg;
    logic [1:0]            term_reg;
    logic                  half_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [63:0]    sq_reg;
    logic [62:0]           s_reg;
    logic [31:0]           n_reg;
    logic                  ov_reg;
    logic signed [31:0]    ow_reg, ox_reg, oy_reg, oz_reg;

    // shared datapath
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    term_t                     term;
    logic signed [BW-1:0]      qext;
    logic signed [31:0]        r_cur;
    logic signed [AW-1:0]      acc_add, acc_next, inc;
    logic signed [CW-1:0]      new_comp;
    logic signed [31:0]        h_new;
    logic signed [63:0]        sq_add, sq_next;
    logic [62:0]               s_next;
    logic [31:0]               mag;
    logic [63:0]               dividend;
    logic signed [31:0]        q_sat;
    logic                      sqrt_start, sqrt_done, div_start, div_done, div_ovf;
    logic [31:0]               root, quot;

    assign term  = step_term(k_reg, term_reg);
    assign qext  = BW'(att_reg[term.qsel]);
    assign r_cur = to_q30(att_reg[k_reg]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_HMUL:
            begin
                mul_a = rate_reg[k_reg];
                mul_b = $signed({1'b0, dt_reg});
            end
            S_QMUL:
            begin
                mul_a = h_reg[term.hsel];
                // low 24 bits unsigned first, then the signed upper part
                mul_b = half_reg ? MUL_B_W'($signed(qext[BW-1:24]))
                                 : $signed({1'b0, qext[23:0]});
            end
            S_SMUL:
            begin
                mul_a = r_cur;
                mul_b = half_reg ? MUL_B_W'($signed(r_cur[31:24]))
                                 : $signed({1'b0, r_cur[23:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    qri_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // half-angle term, rounded ties up, saturated to 32 bits
    assign h_new = sat_q32((XW'(mul_p) + XW'(1024)) >>> 11);

    // one step increment, rounded at 2^-30
    assign acc_add  = half_reg ? (AW'(mul_p) <<< 24) : AW'(mul_p);
    assign acc_next = term.neg ? acc_reg - acc_add : acc_reg + acc_add;
    assign inc      = (acc_next + HALF_LSB) >>> 30;
    assign new_comp = sat_comp(XW'(att_reg[k_reg]) + XW'(inc));

    // sum of squares, each square floored by four
    assign sq_add  = half_reg ? (64'(mul_p) <<< 24) : 64'(mul_p);
    assign sq_next = sq_reg + sq_add;
    assign s_next  = s_reg + 63'(sq_next[63:2]);

    // |r| * 2^29 + n/2, divided by n
    assign mag      = r_cur[31] ? 32'(~r_cur + 32'sd1) : r_cur;
    assign dividend = {3'd0, mag, 29'd0} + {33'd0, n_reg[31:1]};

    assign sqrt_start = (state_reg == S_SQST);
    assign div_start  = (state_reg == S_DVST);

    qri_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (s_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    qri_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (n_reg),
        .done     (div_done),
        .quot     (quot),
        .ovf      (div_ovf)
    );

    // quotient back to a signed Q1.30 value, saturated
    always_comb
    begin
        if (r_cur[31])
            q_sat = (div_ovf || quot > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(quot);
        else
            q_sat = (div_ovf || quot > 32'h7fff_ffff) ? 32'sh7fff_ffff : $signed(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            dt_reg     <= STEP_TIME_RST;
            renorm_reg <= RENORM_RST;
            att_reg[0] <= ONE;
            att_reg[1] <= '0;
            att_reg[2] <= '0;
            att_reg[3] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                qn_reg[i]   <= '0;
                rate_reg[i] <= '0;
                h_reg[i]    <= '0;
            end
            k_reg    <= '0;
            term_reg <= '0;
            half_reg <= 1'b0;
            acc_reg  <= '0;
            sq_reg   <= '0;
            s_reg    <= '0;
            n_reg    <= '0;
            ov_reg   <= 1'b0;
            ow_reg   <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
            oz_reg   <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == REG_STEP_TIME)
                    dt_reg <= cfg.data;
                else if (cfg.index == REG_RENORM)
                    renorm_reg <= cfg.data[0];
            end

            if (ov_reg && res.ready)
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.op)
                        begin
                            att_reg[0] <= from_q30(req.load_w);
                            att_reg[1] <= from_q30(req.load_x);
                            att_reg[2] <= from_q30(req.load_y);
                            att_reg[3] <= from_q30(req.load_z);
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            rate_reg[0] <= req.rate_x;
                            rate_reg[1] <= req.rate_y;
                            rate_reg[2] <= req.rate_z;
                            k_reg       <= '0;
                            state_reg   <= S_HMUL;
                        end
                    end
                end
                S_HMUL:
                    state_reg <= S_HACC;
                S_HACC:
                begin
                    h_reg[k_reg] <= h_new;
                    if (k_reg == AX_Z)
                    begin
                        k_reg     <= '0;
                        term_reg  <= '0;
                        half_reg  <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= S_QMUL;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_HMUL;
                    end
                end
                S_QMUL:
                    state_reg <= S_QACC;
                S_QACC:
                begin
                    acc_reg   <= acc_next;
                    half_reg  <= ~half_reg;
                    state_reg <= S_QMUL;
                    if (half_reg)
                    begin
                        if (term_reg == 2'd2)
                        begin
                            term_reg <= '0;
                            acc_reg  <= '0;
                            if (k_reg == QC_Z)
                            begin
                                // all four from the old attitude; commit together
                                att_reg[0] <= qn_reg[0];
                                att_reg[1] <= qn_reg[1];
                                att_reg[2] <= qn_reg[2];
                                att_reg[3] <= new_comp;
                                k_reg      <= '0;
                                sq_reg     <= '0;
                                s_reg      <= '0;
                                state_reg  <= renorm_reg ? S_SMUL : S_DONE;
                            end
                            else
                            begin
                                qn_reg[k_reg] <= new_comp;
                                k_reg         <= k_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            term_reg <= term_reg + 2'd1;
                        end
                    end
                end
                S_SMUL:
                    state_reg <= S_SACC;
                S_SACC:
                begin
                    sq_reg    <= sq_next;
                    half_reg  <= ~half_reg;
                    state_reg <= S_SMUL;
                    if (half_reg)
                    begin
                        sq_reg <= '0;
                        s_reg  <= s_next;
                        if (k_reg == QC_Z)
                        begin
                            k_reg     <= '0;
                            state_reg <= S_SQST;
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end
                end
                S_SQST:
                    state_reg <= S_SQRT;
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        n_reg <= root;
                        k_reg <= '0;
                        if (root == 32'd0)
                        begin
                            // zero norm falls back to identity
                            att_reg[0] <= ONE;
                            att_reg[1] <= '0;
                            att_reg[2] <= '0;
                            att_reg[3] <= '0;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_DVST;
                        end
                    end
                end
                S_DVST:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        att_reg[k_reg] <= from_q30(q_sat);
                        if (k_reg == QC_Z)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_DVST;
                        end
                    end
                end
                S_DONE:
                begin
                    // result waits here only while the output stage is full and res.ready is low
                    if (!ov_reg || res.ready)
                    begin
                        ov_reg    <= 1'b1;
                        ow_reg    <= to_q30(att_reg[0]);
                        ox_reg    <= to_q30(att_reg[1]);
                        oy_reg    <= to_q30(att_reg[2]);
                        oz_reg    <= to_q30(att_reg[3]);
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign res.valid = ov_reg;
    assign res.att_w = ow_reg;
    assign res.att_x = ox_reg;
    assign res.att_y = oy_reg;
    assign res.att_z = oz_reg;

endmodule

`default_nettype wire

// File: tb/quaternion_rate_integrator_tb.sv
// Testbench for the quaternion rate integrator: drives integrate and load
// requests and configuration writes, checks every result against a predictor.
// Depends on qri_pkg, qri_if and the quaternion_rate_integrator RTL.
`default_nettype none

module quaternion_rate_integrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qri_pkg::*;

    localparam logic OP_INTEGRATE = 1'b0;
    localparam logic OP_LOAD      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;   // no register behind it
    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint S32_MAX    = 64'sd2147483647;
    localparam longint S32_MIN    = -64'sd2147483648;

    typedef struct {
        logic        op;
        logic [31:0] rx, ry, rz;
        logic [31:0] lw, lx, ly, lz;
    } request_t;

    typedef struct packed {
        logic [31:0] w, x, y, z;
    } att_t;

    // directed row: request plus an optional typed-in answer
    typedef struct {
        request_t    rq;
        bit          known;
        att_t        ans;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qri_req_if req ();
    qri_res_if res ();
    qri_cfg_if cfg ();

    quaternion_rate_integrator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state, components held at 32 bits (Q1.30)
    longint            attitude_q[4];
    logic [DT_W-1:0]   dt_reg;
    bit                renorm_reg;

    att_t  pending_att[$];
    int    failures = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(longint v);
        return v < S32_MIN ? S32_MIN : (v > S32_MAX ? S32_MAX : v);
    endfunction

    function automatic longint half_term(logic [31:0] rate);
        longint p;
        p = longint'($signed(rate)) * longint'({40'd0, dt_reg});
        return clip32(shr_floor(p + 1024, 11));
    endfunction

    // rounded sum of three products at 30 fraction bits, split as the block does
    function automatic longint mac_three(longint a0, longint b0, longint a1, longint b1,
                                         longint a2, longint b2);
        longint a[3], b[3], hi, lo, bh;
        a = '{a0, a1, a2};
        b = '{b0, b1, b2};
        hi = 0;
        lo = 64'sd1 << 29;
        for (int i = 0; i < 3; i++)
        begin
            bh = shr_floor(b[i], 24);
            hi += a[i] * bh;
            lo += a[i] * (b[i] - (bh <<< 24));
        end
        return shr_floor(hi + shr_floor(lo, 24), 6);
    endfunction

    function automatic longint root_floor(longint unsigned s);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > s) bt >>= 2;
        while (bt != 0)
        begin
            if (s >= r + bt)
            begin
                s -= r + bt;
                r = (r >> 1) + bt;
            end
            else
                r >>= 1;
            bt >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic void unit_norm();
        longint unsigned sum, mag;
        longint n, num, qv;
        sum = 0;
        for (int i = 0; i < 4; i++)
            sum += longint'(attitude_q[i] * attitude_q[i]) >> 2;
        n = root_floor(sum);
        if (n == 0)
        begin
            attitude_q = '{Q30_ONE, 0, 0, 0};
            return;
        end
        for (int i = 0; i < 4; i++)
        begin
            num = attitude_q[i] <<< 29;
            mag = num < 0 ? -num : num;
            qv = longint'((mag + longint'(n) / 2) / n);
            if (num < 0) qv = -qv;
            attitude_q[i] = clip32(qv);
        end
    endfunction

    function automatic att_t advance_attitude(request_t rq);
        longint hx, hy, hz, q0, q1, q2, q3;
        att_t a;
        if (rq.op == OP_LOAD)
        begin
            attitude_q = '{longint'($signed(rq.lw)), longint'($signed(rq.lx)),
                           longint'($signed(rq.ly)), longint'($signed(rq.lz))};
        end
        else
        begin
            hx = half_term(rq.rx);
            hy = half_term(rq.ry);
            hz = half_term(rq.rz);
            q0 = attitude_q[0]; q1 = attitude_q[1];
            q2 = attitude_q[2]; q3 = attitude_q[3];
            attitude_q[0] = clip32(q0 + mac_three(-hx, q1, -hy, q2, -hz, q3));
            attitude_q[1] = clip32(q1 + mac_three(hx, q0, hz, q2, -hy, q3));
            attitude_q[2] = clip32(q2 + mac_three(hy, q0, -hz, q1, hx, q3));
            attitude_q[3] = clip32(q3 + mac_three(hz, q0, hy, q1, -hx, q2));
            if (renorm_reg) unit_norm();
        end
        a.w = attitude_q[0][31:0];
        a.x = attitude_q[1][31:0];
        a.y = attitude_q[2][31:0];
        a.z = attitude_q[3][31:0];
        return a;
    endfunction

    function automatic request_t load_req(logic [31:0] w, logic [31:0] x,
                                          logic [31:0] y, logic [31:0] z);
        request_t r;
        r = '{OP_LOAD, $urandom, $urandom, $urandom, w, x, y, z};
        return r;
    endfunction

    function automatic request_t rate_req(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        request_t r;
        r = '{OP_INTEGRATE, x, y, z, $urandom, $urandom, $urandom, $urandom};
        return r;
    endfunction

    // random rate: mostly realistic gyro magnitudes, some full range
    function automatic logic [31:0] any_rate();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
        endcase
    endfunction

    function automatic logic [31:0] any_comp();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return 32'h0;
            default: return 32'($signed($urandom_range(0, 32'h7fff_ffff)) - 2 ** 30);
        endcase
    endfunction

    // the other side of the handshake: results checked field by field
    always @(posedge clk)
    begin
        att_t e;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (pending_att.size() == 0)
                begin
                    $error("unexpected result w=%h x=%h y=%h z=%h",
                           res.att_w, res.att_x, res.att_y, res.att_z);
                    failures++;
                end
                else
                begin
                    e = pending_att.pop_front();
                    if (res.att_w !== e.w)
                    begin
                        $error("att_w expected %h actual %h", e.w, res.att_w); failures++;
                    end
                    if (res.att_x !== e.x)
                    begin
                        $error("att_x expected %h actual %h", e.x, res.att_x); failures++;
                    end
                    if (res.att_y !== e.y)
                    begin
                        $error("att_y expected %h actual %h", e.y, res.att_y); failures++;
                    end
                    if (res.att_z !== e.z)
                    begin
                        $error("att_z expected %h actual %h", e.z, res.att_z); failures++;
                    end
                end
            end
            res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // one write, then valid is dropped and the channel left quiet
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DT_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_STEP_TIME) dt_reg = val;
        else if (idx == REG_RENORM) renorm_reg = val[0];
        @(posedge clk);
    endtask

    // wait for all results, then let the block go quiet
    task automatic drain();
        req.valid <= 1'b0;
        while (pending_att.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // valid stays up after a request; the next call replaces it or idles
    task automatic send_request(request_t rq, bit known, att_t ans);
        att_t p;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.op     <= rq.op;
        req.rate_x <= rq.rx;
        req.rate_y <= rq.ry;
        req.rate_z <= rq.rz;
        req.load_w <= rq.lw;
        req.load_x <= rq.lx;
        req.load_y <= rq.ly;
        req.load_z <= rq.lz;
        do @(posedge clk); while (!req.ready);
        p = advance_attitude(rq);
        if (known && p != ans)
        begin
            $error("directed row answer disagrees with predictor");
            failures++;
        end
        pending_att.push_back(known ? ans : p);
    endtask

    initial
    begin
        row_t  rows[$];
        att_t  ident, none;
        int    phase_idle[4] = '{0, 55, 0, 23};
        int    phase_stall[4] = '{0, 0, 55, 23};
        logic [DT_W-1:0] dt_set[4] = '{24'd16777, 24'd0, 24'hffffff, 24'd300000};

        req.valid = 1'b0; req.op = OP_INTEGRATE;
        req.rate_x = '0; req.rate_y = '0; req.rate_z = '0;
        req.load_w = '0; req.load_x = '0; req.load_y = '0; req.load_z = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        dt_reg = STEP_TIME_RST;
        renorm_reg = RENORM_RST;
        attitude_q = '{Q30_ONE, 0, 0, 0};
        ident = '{32'h4000_0000, 0, 0, 0};
        none = '{0, 0, 0, 0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero rate keeps identity; load extremes come straight back
        rows.push_back('{rate_req(0, 0, 0), 1, ident});
        rows.push_back('{load_req(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000),
                         1, '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000}});
        rows.push_back('{rate_req(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 0, none});
        // zero quaternion renormalises to identity
        rows.push_back('{load_req(0, 0, 0, 0), 1, '{0, 0, 0, 0}});
        rows.push_back('{rate_req(0, 0, 0), 1, ident});
        rows.push_back('{rate_req(32'h0001_0000, 0, 0), 0, none});
        rows.push_back('{rate_req(0, 32'hffff_0000, 0), 0, none});
        rows.push_back('{rate_req(0, 0, 32'h0010_0000), 0, none});
        rows.push_back('{load_req(32'h2d41_3ccd, 32'h2d41_3ccd, 0, 0), 0, none});
        rows.push_back('{rate_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, none});
        rows.push_back('{load_req(1, 32'hffff_ffff, 1, 0), 0, none});
        rows.push_back('{rate_req(32'h0000_ffff, 32'h0000_ffff, 32'h0000_ffff), 0, none});
        foreach (rows[i]) send_request(rows[i].rq, rows[i].known, rows[i].ans);
        drain();

        // renormalise off: a load is never normalised, steps accumulate raw
        write_reg(REG_RENORM, '0);
        send_request(load_req(32'h0000_0003, 0, 0, 0), 1, '{32'h3, 0, 0, 0});
        send_request(rate_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0, none);
        send_request(load_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff),
                     0, none);
        send_request(rate_req(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 0, none);
        drain();

        // random phases, each writing its register settings and picking one of four idling mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_STEP_TIME, ph < 4 ? dt_set[ph] : DT_W'($urandom));
            write_reg(REG_RENORM, DT_W'((ph % 3) != 1));
            // a stray index must leave both registers alone
            write_reg(REG_NONE, DT_W'($urandom));
            send_idle_pct = phase_idle[ph % 4];
            recv_stall_pct = phase_stall[ph % 4];
            for (int n = 0; n < 180; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(load_req(any_comp(), any_comp(), any_comp(), any_comp()),
                                 0, none);
                else
                    send_request(rate_req(any_rate(), any_rate(), any_rate()), 0, none);
                // hold off until all answers are back now and then
                if (n == 90)
                begin
                    req.valid <= 1'b0;
                    while (pending_att.size() != 0) @(posedge clk);
                end
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ceiling: time for ~1500 requests plus stalls, taken several times over
    initial
    begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/qri_pkg.sv
hw/rtl/qri_if.sv
hw/rtl/qri_mul.sv
hw/rtl/qri_sqrt.sv
hw/rtl/qri_div.sv
hw/rtl/quaternion_rate_integrator.sv
tb/quaternion_rate_integrator_tb.sv
